/* rtl/core/rtsa_pkg.sv */
// ----------------------------------------------------------------------------
// rtsa_pkg
// Shared types and codes for the ring transfer space allocator.
// ----------------------------------------------------------------------------
package rtsa_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned OP_W   = 2;
  localparam int unsigned LEN_W  = 21;
  localparam int unsigned SEL_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned SS_W   = 2;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [LEN_W-1:0] BUFFER_SIZE_RST = LEN_W'(1048576);

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN    = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_CANCEL   = 2'd2,
    OP_RETIRE   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NO_RETIRE = 2'd3
  } status_t;

  typedef enum logic [SS_W-1:0] {
    SS_EMPTY   = 2'd0,
    SS_LOADING = 2'd1,
    SS_READY   = 2'd2
  } slot_state_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  // Placement decision for a begin request
  typedef struct packed {
    logic no_slot;  // every slot busy
    logic fits;     // enough contiguous space
    logic at_zero;  // region starts at offset zero
  } place_t;

endpackage

/* rtl/core/ring_transfer_space_allocator_unit.sv */
// ----------------------------------------------------------------------------
// ring_transfer_space_allocator_unit
// Contiguous region allocator over a ring buffer with a ring of slots.
// ----------------------------------------------------------------------------
// An accepted item enters the execute state, and its result is registered once the
//   output register is free or being drained; no new item is accepted until execute ends.
//   The region RAM read is issued at acceptance and consumed in the execute cycle.
// A result waiting on out_tready does not block the next item's acceptance.
// Reset (rst_n low, synchronous): pointers, slot counters and handshake state
//   clear, buffer_size returns to 1048576. Region RAM contents are not cleared.
// ----------------------------------------------------------------------------
module ring_transfer_space_allocator_unit #(
  parameter int unsigned SLOT_COUNT  = 16,
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration: buffer_size
  input  logic                                cfg_wr_en,
  input  logic [rtsa_pkg::LEN_W-1:0]          cfg_wr_data,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [20:0] request_bytes, [24:21] slot_select, [31:25] zero
  input  logic [rtsa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] opcode
  input  logic [rtsa_pkg::OP_W-1:0]           in_tuser,
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [3:0] slot_index, [24:4] region_begin, [45:25] region_finish,
  // [47:46] slot_status
  output logic [rtsa_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [1:0] status
  output logic [rtsa_pkg::STAT_W-1:0]         out_tuser
);
  import rtsa_pkg::*;

  // Pointer width: one bit above the offset range so a full buffer is expressible
  localparam int unsigned PW    = OFFSET_BITS + 1;
  localparam int unsigned CW    = (PW > LEN_W) ? PW : LEN_W;
  localparam int unsigned SUM_W = CW + 1;
  localparam int unsigned SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned BW    = $clog2(SLOT_COUNT + 1);

  // Handshake and sequencing
  fsm_t   state_r, state_nxt;
  logic   in_fire;
  logic   exec_go;

  // Captured item
  op_t                 op_r;
  logic [LEN_W-1:0]    req_r;
  logic [SEL_W-1:0]    sel_r;

  // Allocator state
  logic [LEN_W-1:0]    buffer_size_r;
  logic [PW-1:0]       used_start_r, used_start_nxt;
  logic [PW-1:0]       used_end_r,   used_end_nxt;
  logic [SW-1:0]       oldest_r,     oldest_nxt;
  logic [BW-1:0]       busy_r,       busy_nxt;

  // Region RAM
  logic                mem_we;
  logic [SW-1:0]       mem_waddr;
  logic [2*PW-1:0]     mem_wdata;
  logic [SW-1:0]       mem_raddr;
  logic [2*PW-1:0]     mem_rdata;
  logic [PW-1:0]       rd_begin;
  logic [PW-1:0]       rd_end;

  // Begin placement
  place_t              place;
  logic [PW-1:0]       at;
  logic [SUM_W-1:0]    fin_sum;
  logic [PW-1:0]       fin;
  logic [SW:0]         slot_sum;
  logic [SW-1:0]       new_slot;
  logic                sel_bad;

  // Result
  status_t             res_status;
  logic [SEL_W-1:0]    res_slot;
  logic [LEN_W-1:0]    res_begin;
  logic [LEN_W-1:0]    res_finish;
  slot_state_t         res_ss;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [SEL_W-1:0]    out_slot_r;
  logic [LEN_W-1:0]    out_begin_r;
  logic [LEN_W-1:0]    out_finish_r;
  slot_state_t         out_ss_r;

  // ---------------------------------------------------------------------------
  // Sequencer: accept in IDLE, execute once the output register can take it
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (exec_go) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    exec_go   = 1'b0;
    case (state_r)
      FSM_IDLE: in_tready = 1'b1;
      FSM_EXEC: exec_go   = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        exec_go   = 1'b0;
      end
    endcase
  end

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(in_tuser);
      req_r <= in_tdata[LEN_W-1:0];
      sel_r <= in_tdata[LEN_W +: SEL_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Region RAM: read issued at acceptance, written back in the execute cycle
  // Complete and cancel read the selected slot, retire reads the oldest one.
  // ---------------------------------------------------------------------------
  assign mem_raddr = (op_t'(in_tuser) == OP_RETIRE) ? oldest_r
                                                     : SW'(in_tdata[LEN_W +: SEL_W]);

  rtsa_region_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SW),
    .DW    (2 * PW)
  ) u_region_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_fire),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_begin = mem_rdata[PW-1:0];
  assign rd_end   = mem_rdata[2*PW-1:PW];

  // ---------------------------------------------------------------------------
  // Begin placement and slot choice
  // ---------------------------------------------------------------------------
  rtsa_place #(
    .SLOT_COUNT (SLOT_COUNT),
    .PW         (PW),
    .BW         (BW)
  ) u_place (
    .used_start  (used_start_r),
    .used_end    (used_end_r),
    .busy        (busy_r),
    .buffer_size (buffer_size_r),
    .req         (req_r),
    .place       (place)
  );

  assign at       = place.at_zero ? '0 : used_end_r;
  assign fin_sum  = SUM_W'(at) + SUM_W'(req_r);
  assign fin      = fin_sum[PW-1:0];

  // oldest + busy stays below twice the slot count: one compare and subtract
  assign slot_sum = (SW + 1)'(oldest_r) + (SW + 1)'(busy_r);
  assign new_slot = (32'(slot_sum) >= 32'(SLOT_COUNT))
                    ? SW'(32'(slot_sum) - 32'(SLOT_COUNT)) : slot_sum[SW-1:0];

  assign sel_bad  = (32'(sel_r) >= 32'(SLOT_COUNT));

  // ---------------------------------------------------------------------------
  // Execute: build the result, update pointers, write back a granted region.
  // Slot state follows from the operation, so it needs no storage of its own.
  // ---------------------------------------------------------------------------
  always_comb begin
    used_start_nxt = used_start_r;
    used_end_nxt   = used_end_r;
    oldest_nxt     = oldest_r;
    busy_nxt       = busy_r;
    mem_we         = 1'b0;
    mem_waddr      = new_slot;
    mem_wdata      = {fin, at};
    res_status     = ST_OK;
    res_slot       = '0;
    res_begin      = '0;
    res_finish     = '0;
    res_ss         = SS_EMPTY;
    case (op_r)
      OP_BEGIN: begin
        if (place.no_slot) begin
          res_status = ST_NO_SLOT;
        end else if (!place.fits) begin
          res_status = ST_NO_SPACE;
        end else begin
          mem_we       = exec_go;
          busy_nxt     = busy_r + BW'(1);
          used_end_nxt = fin;
          res_slot     = SEL_W'(new_slot);
          res_begin    = LEN_W'(at);
          res_finish   = LEN_W'(fin);
          res_ss       = SS_LOADING;
        end
      end
      OP_COMPLETE, OP_CANCEL: begin
        res_slot = sel_r;
        // hold everything else at zero for a slot beyond the ring
        if (!sel_bad) begin
          res_begin  = LEN_W'(rd_begin);
          res_finish = LEN_W'(rd_end);
          res_ss     = (op_r == OP_COMPLETE) ? SS_READY : SS_EMPTY;
        end
      end
      OP_RETIRE: begin
        if (busy_r == '0) begin
          res_status = ST_NO_RETIRE;
        end else begin
          used_start_nxt = rd_end;
          oldest_nxt     = (32'(oldest_r) == 32'(SLOT_COUNT - 1))
                           ? '0 : oldest_r + SW'(1);
          busy_nxt       = busy_r - BW'(1);
          res_slot       = SEL_W'(oldest_r);
          res_begin      = LEN_W'(rd_begin);
          res_finish     = LEN_W'(rd_end);
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_start_r <= '0;
      used_end_r   <= '0;
      oldest_r     <= '0;
      busy_r       <= '0;
    end else if (exec_go) begin
      used_start_r <= used_start_nxt;
      used_end_r   <= used_end_nxt;
      oldest_r     <= oldest_nxt;
      busy_r       <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_size_r <= BUFFER_SIZE_RST;
    end else if (cfg_wr_en) begin
      buffer_size_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign out_valid_nxt = exec_go ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_begin_r  <= res_begin;
      out_finish_r <= res_finish;
      out_ss_r     <= res_ss;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_ss_r, out_finish_r, out_begin_r, out_slot_r};

`ifndef SYNTH
  a_busy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(busy_r) <= 32'(SLOT_COUNT))
    else $error("busy slot count exceeds slot count");

  a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(oldest_r) < 32'(SLOT_COUNT))
    else $error("oldest slot index out of range");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == FSM_EXEC))
    else $error("accepted item did not enter execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == FSM_EXEC))
    else $error("result appeared without an execute cycle");

  a_write_only_begin: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (exec_go && op_r == OP_BEGIN && busy_r != BW'(SLOT_COUNT)))
    else $error("region RAM written outside a granted begin");
`endif

endmodule

/* rtl/core/rtsa_region_ram.sv */
// ----------------------------------------------------------------------------
// rtsa_region_ram
// Per-slot region bounds, one write and one registered read port.
// ----------------------------------------------------------------------------
module rtsa_region_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 42
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/rtsa_place.sv */
// ----------------------------------------------------------------------------
// rtsa_place
// Finds where a begin request fits in the ring buffer.
// ----------------------------------------------------------------------------
module rtsa_place #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned PW         = 21,
  parameter int unsigned BW         = 5
) (
  input  logic [PW-1:0]              used_start,
  input  logic [PW-1:0]              used_end,
  input  logic [BW-1:0]              busy,
  input  logic [rtsa_pkg::LEN_W-1:0] buffer_size,
  input  logic [rtsa_pkg::LEN_W-1:0] req,
  output rtsa_pkg::place_t           place
);
  import rtsa_pkg::*;

  localparam int unsigned CW = (PW > LEN_W) ? PW : LEN_W;

  logic [CW-1:0] us;
  logic [CW-1:0] ue;
  logic [CW-1:0] bs;
  logic [CW-1:0] rq;
  logic [CW-1:0] tail;
  logic [CW-1:0] avail;
  logic          at_zero;

  assign us = CW'(used_start);
  assign ue = CW'(used_end);
  assign bs = CW'(buffer_size);
  assign rq = CW'(req);

  // tail counts as zero when the end lies beyond a lowered buffer size
  assign tail = (ue < bs) ? (bs - ue) : '0;

  always_comb begin
    avail   = '0;
    at_zero = 1'b0;
    if (us == ue) begin
      if (busy == '0) begin
        avail   = bs;
        at_zero = 1'b1;
      end
    end else if (ue < us) begin
      avail = us - ue;
    end else if (tail < rq) begin
      avail   = us;
      at_zero = 1'b1;
    end else begin
      avail = tail;
    end
  end

  assign place.no_slot = (32'(busy) >= 32'(SLOT_COUNT));
  assign place.fits    = (avail >= rq);
  assign place.at_zero = at_zero;

endmodule
